FILE: rtl/iqtc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iqtc_pkg: shared types and codes of the interrupt queue
// Request and response payloads, the stored entry layout, item kinds,
// status codes and the sequencer states.
// ----------------------------------------------------------------------------
package iqtc_pkg;

	// Width of the count fields in a response
	localparam int CNT_FIELD_W = 5;

	// Item kinds
	localparam logic [1:0] KIND_ENQ = 2'd0;
	localparam logic [1:0] KIND_DEQ = 2'd1;
	localparam logic [1:0] KIND_CLR = 2'd2;

	// Response status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic        [1:0]  kind;
		logic        [7:0]  intr_type;
		logic signed [31:0] intr_value;
		logic signed [31:0] intr_misc;
		logic               remove_every;
	} req_t;

	typedef struct packed {
		logic        [1:0]             status;
		logic        [7:0]             got_type;
		logic signed [31:0]            got_value;
		logic signed [31:0]            got_misc;
		logic        [CNT_FIELD_W-1:0] removed;
		logic        [CNT_FIELD_W-1:0] occupancy;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  itype;
		logic [31:0] ival;
		logic [31:0] imisc;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEQ,
		ST_CLR,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/iqtc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iqtc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module iqtc_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/iqtc_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iqtc_match: type compare unit of the clear sweep
// Decides whether the entry under the sweep is removed.
// ----------------------------------------------------------------------------
module iqtc_match (
	input  wire logic [7:0] entry_type,
	input  wire logic [7:0] key_type,
	input  wire logic       remove_every,
	input  wire logic       first_removed,
	output logic            hit
);

	// Remove on a type match, only once unless every match goes
	always_comb begin
		hit = (entry_type == key_type) && (remove_every || !first_removed);
	end

endmodule
`default_nettype wire

FILE: rtl/interrupt_queue_with_type_clear.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interrupt_queue_with_type_clear: queued interrupt controller
// FIFO of pending interrupts held in a circular RAM, with enqueue, dequeue
// and clear-by-type that compacts the queue in one sweep.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid, req_stall, req) carries one item per transfer:
//   enqueue, dequeue oldest, or clear by type. rsp channel (rsp_valid,
//   rsp_stall, rsp) returns exactly one response per item, in order.
//   The block takes one item at a time; req_stall is high while an item is
//   in work. From request transfer to response valid the sequencer passes:
//     enqueue, full, empty, clear on empty queue, unused kind: ST_EMIT
//     dequeue: ST_DEQ (one RAM read), then ST_EMIT
//     clear: ST_CLR (one RAM read and one compare per entry, through
//     the single read port and the shared compare unit), then ST_EMIT;
//   ST_EMIT loads the output register. The next item is taken in the
//   cycle after the response is loaded, so one item is done before the next.
//   A response waits in the output register while rsp_stall is high; the
//   next item may be taken meanwhile, and its result waits in the
//   sequencer until the output register frees.
//   Reset empties the queue at once; the RAM itself is not cleared.
// ----------------------------------------------------------------------------
module interrupt_queue_with_type_clear #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire iqtc_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output iqtc_pkg::rsp_t      rsp
);

	import iqtc_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int XW = (CW > CNT_FIELD_W) ? CW : CNT_FIELD_W;

	// Circular pointer advance
	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	// Fit a count into a response field
	function automatic logic [CNT_FIELD_W-1:0] cnt_field(input logic [CW-1:0] v);
		logic [XW-1:0] x;
		x = XW'(v);
		return x[CNT_FIELD_W-1:0];
	endfunction

	state_t        state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] tail_q, tail_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] rd_ptr_q, rd_ptr_d;
	logic [AW-1:0] wr_ptr_q, wr_ptr_d;
	logic [CW-1:0] issue_left_q, issue_left_d;
	logic [CW-1:0] proc_left_q, proc_left_d;
	logic [CW-1:0] nrem_q, nrem_d;
	logic [7:0]    key_q, key_d;
	logic          every_q, every_d;
	rsp_t          res_q, res_d;
	logic          rsp_valid_q, rsp_valid_d;
	rsp_t          rsp_q;
	logic          load_rsp;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	entry_t        ram_wdata;
	entry_t        ram_rdata;
	logic          hit;
	logic [CW-1:0] nrem_nx;
	logic [AW-1:0] wr_nx;

	iqtc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	iqtc_match u_match (
		.entry_type   (ram_rdata.itype),
		.key_type     (key_q),
		.remove_every (every_q),
		.first_removed(nrem_q != '0),
		.hit          (hit)
	);

	// Sequencer: next state, RAM control and result assembly
	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		tail_d       = tail_q;
		count_d      = count_q;
		rd_ptr_d     = rd_ptr_q;
		wr_ptr_d     = wr_ptr_q;
		issue_left_d = issue_left_q;
		proc_left_d  = proc_left_q;
		nrem_d       = nrem_q;
		key_d        = key_q;
		every_d      = every_q;
		res_d        = res_q;
		load_rsp     = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = tail_q;
		ram_raddr    = head_q;
		ram_wdata    = '{itype: req.intr_type, ival: req.intr_value, imisc: req.intr_misc};
		nrem_nx      = nrem_q;
		wr_nx        = wr_ptr_q;

		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					res_d           = '0;
					res_d.status    = STAT_OK;
					res_d.occupancy = cnt_field(count_q);
					key_d           = req.intr_type;
					every_d         = req.remove_every;
					state_d         = ST_EMIT;
					case (req.kind)
						KIND_ENQ: begin
							if (count_q == CW'(QUEUE_DEPTH)) begin
								res_d.status = STAT_FULL;
							end else begin
								ram_we          = 1'b1;
								tail_d          = ptr_inc(tail_q);
								count_d         = count_q + CW'(1);
								res_d.occupancy = cnt_field(count_q + CW'(1));
							end
						end
						KIND_DEQ: begin
							if (count_q == '0) begin
								res_d.status = STAT_EMPTY;
							end else begin
								state_d = ST_DEQ;
							end
						end
						KIND_CLR: begin
							if (count_q != '0) begin
								rd_ptr_d     = ptr_inc(head_q);
								issue_left_d = count_q - CW'(1);
								proc_left_d  = count_q;
								wr_ptr_d     = head_q;
								nrem_d       = '0;
								state_d      = ST_CLR;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_DEQ: begin
				// Head entry read was issued at the transfer
				res_d.got_type  = ram_rdata.itype;
				res_d.got_value = ram_rdata.ival;
				res_d.got_misc  = ram_rdata.imisc;
				head_d          = ptr_inc(head_q);
				count_d         = count_q - CW'(1);
				res_d.occupancy = cnt_field(count_q - CW'(1));
				state_d         = ST_EMIT;
			end
			ST_CLR: begin
				// Issue the next read while the previous entry is checked
				ram_raddr = rd_ptr_q;
				if (issue_left_q != '0) begin
					rd_ptr_d     = ptr_inc(rd_ptr_q);
					issue_left_d = issue_left_q - CW'(1);
				end
				// Drop a hit, move a keeper down to the write pointer
				if (hit) begin
					nrem_nx = nrem_q + CW'(1);
				end else begin
					ram_we    = 1'b1;
					ram_waddr = wr_ptr_q;
					ram_wdata = ram_rdata;
					wr_nx     = ptr_inc(wr_ptr_q);
				end
				nrem_d      = nrem_nx;
				wr_ptr_d    = wr_nx;
				proc_left_d = proc_left_q - CW'(1);
				if (proc_left_q == CW'(1)) begin
					tail_d          = wr_nx;
					count_d         = count_q - nrem_nx;
					res_d.removed   = cnt_field(nrem_nx);
					res_d.occupancy = cnt_field(count_q - nrem_nx);
					state_d         = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// Hand the result over once the output register frees
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the response until its transfer completes
	always_comb begin
		if (load_rsp) begin
			rsp_valid_d = 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_d = 1'b0;
		end else begin
			rsp_valid_d = rsp_valid_q;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			rd_ptr_q     <= '0;
			wr_ptr_q     <= '0;
			issue_left_q <= '0;
			proc_left_q  <= '0;
			nrem_q       <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			head_q       <= head_d;
			tail_q       <= tail_d;
			count_q      <= count_d;
			rd_ptr_q     <= rd_ptr_d;
			wr_ptr_q     <= wr_ptr_d;
			issue_left_q <= issue_left_d;
			proc_left_q  <= proc_left_d;
			nrem_q       <= nrem_d;
			rsp_valid_q  <= rsp_valid_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		key_q   <= key_d;
		every_q <= every_d;
		res_q   <= res_d;
		if (load_rsp) begin
			rsp_q <= res_q;
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Occupancy stays within the queue depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count above depth");

	// A clear never removes more entries than the queue holds
	a_nrem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> (nrem_q <= count_q))
		else $error("clear removed more than occupancy");

	// An accepted enqueue into a non-full queue grows it by one
	a_enq_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && req.kind == KIND_ENQ
			&& count_q != CW'(QUEUE_DEPTH))
		|=> (count_q == $past(count_q) + CW'(1)))
		else $error("enqueue did not grow the queue");

	// A response only appears after the sequencer hands it over
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == ST_EMIT))
		else $error("response raised outside hand-over");

	// The sequencer never leaves a pending result behind
	a_emit_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !rsp_stall) |=> (state_q == ST_IDLE))
		else $error("result not handed over with free output");

endmodule
`default_nettype wire
